// File: rtl/square_to_quad_homography_defines.svh
// ----------------------------------------------------------------------------
// square_to_quad_homography_defines
// assertion macros shared by the homography block
// ----------------------------------------------------------------------------
`ifndef SQUARE_TO_QUAD_HOMOGRAPHY_DEFINES_SVH
`define SQUARE_TO_QUAD_HOMOGRAPHY_DEFINES_SVH
`ifndef SYNTH
`define SQH_ASSERT_IMPLY(lbl, clk, rst, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define SQH_ASSERT_NEXT(lbl, clk, rst, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`else
`define SQH_ASSERT_IMPLY(lbl, clk, rst, a, c, msg)
`define SQH_ASSERT_NEXT(lbl, clk, rst, a, c, msg)
`endif
`endif

// File: rtl/sqh_pkg.sv
// ----------------------------------------------------------------------------
// sqh_pkg
// types and constants of the square to quad homography block
// ----------------------------------------------------------------------------
package sqh_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int DIV_BITS    = 4;
  localparam int DIV_QW      = 36;
  localparam int DIV_STEPS   = DIV_QW / DIV_BITS;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  typedef struct packed {
    logic signed [15:0] corner0_x;
    logic signed [15:0] corner0_y;
    logic signed [15:0] corner1_x;
    logic signed [15:0] corner1_y;
    logic signed [15:0] corner2_x;
    logic signed [15:0] corner2_y;
    logic signed [15:0] corner3_x;
    logic signed [15:0] corner3_y;
  } quad_t;

  typedef struct packed {
    logic signed [39:0] coef_a;
    logic signed [39:0] coef_b;
    logic signed [15:0] coef_c;
    logic signed [39:0] coef_d;
    logic signed [39:0] coef_e;
    logic signed [15:0] coef_f;
    logic signed [31:0] persp_g;
    logic signed [31:0] persp_h;
    logic               is_affine;
    logic               degenerate;
  } coefs_t;

  // one classified quad waiting for the back end
  typedef struct packed {
    logic signed [35:0] numg;
    logic signed [35:0] numh;
    logic signed [34:0] den;
    logic               affine;
    logic               degen;
    logic signed [15:0] x0;
    logic signed [15:0] y0;
    logic signed [15:0] x1;
    logic signed [15:0] x2;
    logic signed [15:0] y1;
    logic signed [15:0] y2;
    logic signed [16:0] dpa;
    logic signed [16:0] dpb;
    logic signed [16:0] dpd;
    logic signed [16:0] dpe;
  } sqh_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } sqh_qstat_t;

endpackage

// File: rtl/sqh_queue.sv
// ----------------------------------------------------------------------------
// sqh_queue
// small queue between the classifying front end and the solving back end
// ----------------------------------------------------------------------------
module sqh_queue
  import sqh_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  sqh_entry_t wdata,
  input  logic       pop,
  output sqh_entry_t rdata,
  output sqh_qstat_t stat
);

  sqh_entry_t          mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign rdata      = mem[rd_ptr];
  assign stat.empty = (count == '0);
  assign stat.full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));

endmodule

// File: rtl/sqh_front.sv
// ----------------------------------------------------------------------------
// sqh_front
// takes quads, forms corner differences and determinants, classifies them
// ----------------------------------------------------------------------------
module sqh_front
  import sqh_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       valid,
  output logic       stall,
  input  quad_t      quad,
  output logic       push,
  output sqh_entry_t entry,
  input  logic       full
);

  // stage 1: differences
  logic               s1_v;
  logic signed [16:0] dx1, dx2, dy1, dy2;
  logic signed [17:0] dx3, dy3;
  logic signed [15:0] s1_x0, s1_y0, s1_x1, s1_x2, s1_y1, s1_y2;
  logic signed [16:0] s1_dpa, s1_dpb, s1_dpd, s1_dpe;
  logic               s1_affine;

  // stage 2: products
  logic               s2_v;
  logic signed [33:0] p_dx1dy2, p_dy1dx2;
  logic signed [34:0] p_dx3dy2, p_dy3dx2, p_dx1dy3, p_dy1dx3;
  logic signed [15:0] s2_x0, s2_y0, s2_x1, s2_x2, s2_y1, s2_y2;
  logic signed [16:0] s2_dpa, s2_dpb, s2_dpd, s2_dpe;
  logic               s2_affine;

  logic s2_ready;
  logic s1_move;
  logic take;
  logic signed [17:0] dx3_next, dy3_next;

  assign s2_ready = !s2_v || !full;
  assign s1_move  = s1_v && s2_ready;
  assign stall    = s1_v && !s2_ready;
  assign take     = valid && !stall;
  assign push     = s2_v && !full;

  assign dx3_next = 18'(quad.corner0_x) - 18'(quad.corner1_x)
                  + 18'(quad.corner3_x) - 18'(quad.corner2_x);
  assign dy3_next = 18'(quad.corner0_y) - 18'(quad.corner1_y)
                  + 18'(quad.corner3_y) - 18'(quad.corner2_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      if (take) begin
        s1_v <= 1'b1;
      end else if (s1_move) begin
        s1_v <= 1'b0;
      end
      if (s1_move) begin
        s2_v <= 1'b1;
      end else if (push) begin
        s2_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      dx1       <= 17'(quad.corner1_x) - 17'(quad.corner3_x);
      dx2       <= 17'(quad.corner2_x) - 17'(quad.corner3_x);
      dy1       <= 17'(quad.corner1_y) - 17'(quad.corner3_y);
      dy2       <= 17'(quad.corner2_y) - 17'(quad.corner3_y);
      dx3       <= dx3_next;
      dy3       <= dy3_next;
      s1_affine <= (dx3_next == '0) && (dy3_next == '0);
      s1_x0     <= quad.corner0_x;
      s1_y0     <= quad.corner0_y;
      s1_x1     <= quad.corner1_x;
      s1_x2     <= quad.corner2_x;
      s1_y1     <= quad.corner1_y;
      s1_y2     <= quad.corner2_y;
      s1_dpa    <= 17'(quad.corner1_x) - 17'(quad.corner0_x);
      s1_dpd    <= 17'(quad.corner1_y) - 17'(quad.corner0_y);
      // parallelogram uses the far edge for the second column
      if ((dx3_next == '0) && (dy3_next == '0)) begin
        s1_dpb <= 17'(quad.corner3_x) - 17'(quad.corner1_x);
        s1_dpe <= 17'(quad.corner3_y) - 17'(quad.corner1_y);
      end else begin
        s1_dpb <= 17'(quad.corner2_x) - 17'(quad.corner0_x);
        s1_dpe <= 17'(quad.corner2_y) - 17'(quad.corner0_y);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      p_dx1dy2  <= 34'(dx1) * 34'(dy2);
      p_dy1dx2  <= 34'(dy1) * 34'(dx2);
      p_dx3dy2  <= 35'(dx3) * 35'(dy2);
      p_dy3dx2  <= 35'(dy3) * 35'(dx2);
      p_dx1dy3  <= 35'(dx1) * 35'(dy3);
      p_dy1dx3  <= 35'(dy1) * 35'(dx3);
      s2_affine <= s1_affine;
      s2_x0     <= s1_x0;
      s2_y0     <= s1_y0;
      s2_x1     <= s1_x1;
      s2_x2     <= s1_x2;
      s2_y1     <= s1_y1;
      s2_y2     <= s1_y2;
      s2_dpa    <= s1_dpa;
      s2_dpb    <= s1_dpb;
      s2_dpd    <= s1_dpd;
      s2_dpe    <= s1_dpe;
    end
  end

  always_comb begin
    entry.den    = 35'(p_dx1dy2) - 35'(p_dy1dx2);
    entry.numg   = 36'(p_dx3dy2) - 36'(p_dy3dx2);
    entry.numh   = 36'(p_dx1dy3) - 36'(p_dy1dx3);
    entry.affine = s2_affine;
    entry.degen  = !s2_affine && (p_dx1dy2 == p_dy1dx2);
    entry.x0     = s2_x0;
    entry.y0     = s2_y0;
    entry.x1     = s2_x1;
    entry.x2     = s2_x2;
    entry.y1     = s2_y1;
    entry.y2     = s2_y2;
    entry.dpa    = s2_dpa;
    entry.dpb    = s2_dpb;
    entry.dpd    = s2_dpd;
    entry.dpe    = s2_dpe;
  end

endmodule

// File: rtl/sqh_div.sv
// ----------------------------------------------------------------------------
// sqh_div
// iterative rounding divider, num * 2^16 / den to saturated Q16.16
// ----------------------------------------------------------------------------
module sqh_div
  import sqh_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [35:0] num,
  input  logic signed [34:0] den,
  output logic               done,
  output logic signed [31:0] quo
);

  logic                  busy;
  logic [DIV_CNT_W-1:0]  cnt;
  logic                  neg;
  logic                  ov;
  logic [34:0]           ud;
  logic [35:0]           rem;
  logic [35:0]           low;
  logic [DIV_QW-1:0]     q;

  logic [35:0] un_s;
  logic [34:0] ud_s;
  logic [51:0] u_s;
  logic [35:0] rem_next, low_next, rr;
  logic [DIV_QW-1:0] q_next;

  assign un_s = num[35] ? 36'(-num) : 36'(num);
  assign ud_s = den[34] ? 35'(-den) : 35'(den);
  // bias by half the divisor so the truncating quotient rounds
  assign u_s  = {un_s, 16'b0} + 52'(ud_s >> 1);

  always_comb begin
    rem_next = rem;
    low_next = low;
    q_next   = q;
    rr       = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      rr       = {rem_next[34:0], low_next[35]};
      low_next = {low_next[34:0], 1'b0};
      if (rr >= 36'(ud)) begin
        rem_next = rr - 36'(ud);
        q_next   = {q_next[DIV_QW-2:0], 1'b1};
      end else begin
        rem_next = rr;
        q_next   = {q_next[DIV_QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= num[35] ^ den[34];
      ud  <= ud_s;
      ov  <= 35'(u_s[51:36]) >= ud_s;
      rem <= 36'(u_s[51:36]);
      low <= u_s[35:0];
      q   <= '0;
    end else if (busy) begin
      rem <= rem_next;
      low <= low_next;
      q   <= q_next;
    end
  end

  always_comb begin
    if (neg) begin
      if (ov || (q > DIV_QW'(33'h080000000))) begin
        quo = 32'sh80000000;
      end else begin
        quo = 32'(-q);
      end
    end else begin
      if (ov || (q > DIV_QW'(32'h7fffffff))) begin
        quo = 32'sh7fffffff;
      end else begin
        quo = 32'(q);
      end
    end
  end

endmodule

// File: rtl/sqh_back.sv
// ----------------------------------------------------------------------------
// sqh_back
// solves perspective terms and forms the coefficient set of one quad
// ----------------------------------------------------------------------------
`include "square_to_quad_homography_defines.svh"

module sqh_back
  import sqh_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  sqh_qstat_t qstat,
  input  sqh_entry_t head,
  output logic       pop,
  output logic       coef_valid,
  input  logic       coef_stall,
  output coefs_t     coefs
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]         state;
  sqh_entry_t         ent;
  logic signed [31:0] g, h;
  logic signed [47:0] kpa, kpb, kpd, kpe;
  logic               div_done_g, div_done_h;
  logic signed [31:0] quo_g, quo_h;
  logic               load;

  function automatic logic signed [39:0] round_sat(input logic signed [16:0] dp,
                                                   input logic signed [47:0] kp);
    logic signed [49:0] v;
    logic [49:0]        mag;
    logic [49:0]        r;
    logic signed [49:0] sv;
    v   = (50'(dp) <<< 16) + 50'(kp);
    mag = v[49] ? 50'(-v) : 50'(v);
    r   = (mag + 50'd8) >> 4;
    sv  = v[49] ? 50'(-r) : 50'(r);
    if (sv > 50'sh7fffffffff) begin
      return 40'sh7fffffffff;
    end else if (sv < -50'sh8000000000) begin
      return 40'sh8000000000;
    end else begin
      return 40'(sv);
    end
  endfunction

  assign pop  = (state == S_IDLE) && !qstat.empty;
  assign load = (state == S_FIN) && (!coef_valid || !coef_stall);

  sqh_div u_div_g (
    .clk   (clk),
    .rst   (rst),
    .start (pop),
    .num   (head.numg),
    .den   (head.den),
    .done  (div_done_g),
    .quo   (quo_g)
  );

  sqh_div u_div_h (
    .clk   (clk),
    .rst   (rst),
    .start (pop),
    .num   (head.numh),
    .den   (head.den),
    .done  (div_done_h),
    .quo   (quo_h)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      coef_valid <= 1'b0;
    end else begin
      if (load) begin
        coef_valid <= 1'b1;
      end else if (!coef_stall) begin
        coef_valid <= 1'b0;
      end
      case (state)
        S_IDLE:  if (pop) state <= S_DIV;
        S_DIV:   if (div_done_g) state <= S_MUL;
        S_MUL:   state <= S_FIN;
        S_FIN:   if (load) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ent <= head;
    end
    if ((state == S_DIV) && div_done_g) begin
      // parallelogram or zero divisor: no perspective terms
      g <= (ent.affine || ent.degen) ? '0 : quo_g;
      h <= (ent.affine || ent.degen) ? '0 : quo_h;
    end
    if (state == S_MUL) begin
      kpa <= 48'(g) * 48'(ent.x1);
      kpb <= 48'(h) * 48'(ent.x2);
      kpd <= 48'(g) * 48'(ent.y1);
      kpe <= 48'(h) * 48'(ent.y2);
    end
    if (load) begin
      coefs.coef_a     <= round_sat(ent.dpa, kpa);
      coefs.coef_b     <= round_sat(ent.dpb, kpb);
      coefs.coef_c     <= ent.x0;
      coefs.coef_d     <= round_sat(ent.dpd, kpd);
      coefs.coef_e     <= round_sat(ent.dpe, kpe);
      coefs.coef_f     <= ent.y0;
      coefs.persp_g    <= g;
      coefs.persp_h    <= h;
      coefs.is_affine  <= ent.affine;
      coefs.degenerate <= ent.degen;
    end
  end

  `SQH_ASSERT_IMPLY(a_div_lockstep, clk, rst, div_done_g || div_done_h, div_done_g && div_done_h, "dividers out of step")
  `SQH_ASSERT_IMPLY(a_flat_persp, clk, rst, coef_valid && (coefs.is_affine || coefs.degenerate), (coefs.persp_g == '0) && (coefs.persp_h == '0), "perspective terms not zero")
  `SQH_ASSERT_IMPLY(a_flags_excl, clk, rst, coef_valid, !(coefs.is_affine && coefs.degenerate), "affine and degenerate both set")
  `SQH_ASSERT_NEXT(a_pop_starts, clk, rst, pop, state == S_DIV, "pop did not start division")

endmodule

// File: rtl/square_to_quad_homography.sv
// the back end takes one quad at a time, paced by the 9-step radix-16 dividers
// the front end and a 4-entry queue keep taking quads while the back end works
// reset clears all handshake and sequencing state; no clearing pass is needed
// ----------------------------------------------------------------------------
// square_to_quad_homography
// projective matrix mapping the unit square onto a quadrilateral
// ----------------------------------------------------------------------------
module square_to_quad_homography
  import sqh_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   quad_valid,
  output logic   quad_stall,
  input  quad_t  quad,
  output logic   coef_valid,
  input  logic   coef_stall,
  output coefs_t coefs
);

  logic       push;
  logic       pop;
  sqh_entry_t wentry;
  sqh_entry_t rentry;
  sqh_qstat_t qstat;

  sqh_front u_front (
    .clk   (clk),
    .rst   (rst),
    .valid (quad_valid),
    .stall (quad_stall),
    .quad  (quad),
    .push  (push),
    .entry (wentry),
    .full  (qstat.full)
  );

  sqh_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (wentry),
    .pop   (pop),
    .rdata (rentry),
    .stat  (qstat)
  );

  sqh_back u_back (
    .clk        (clk),
    .rst        (rst),
    .qstat      (qstat),
    .head       (rentry),
    .pop        (pop),
    .coef_valid (coef_valid),
    .coef_stall (coef_stall),
    .coefs      (coefs)
  );

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// checks the square to quad homography block against a fixed-point predictor,
// using a directed table of quads followed by random quads with bursty
// traffic and receiver stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import sqh_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int N_RANDOM = 1100;
  localparam int N_DIRECTED = 12;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic quad_valid = 1'b0;
  logic quad_stall;
  quad_t quad = '0;
  logic coef_valid;
  logic coef_stall = 1'b0;
  coefs_t coefs;

  coefs_t expected_coefs[$];
  int errors = 0;
  int idle_cycles = 0;
  bit stim_done = 1'b0;

  always #10 clk = ~clk;

  square_to_quad_homography i_dut (
    .clk(clk), .rst(rst),
    .quad_valid(quad_valid), .quad_stall(quad_stall), .quad(quad),
    .coef_valid(coef_valid), .coef_stall(coef_stall), .coefs(coefs)
  );

  function automatic longint rnd_div(longint n, longint d);
    bit neg;
    longint un, ud;
    neg = (n < 0) != (d < 0);
    un = n < 0 ? -n : n;
    ud = d < 0 ? -d : d;
    return neg ? -((un + ud / 2) / ud) : (un + ud / 2) / ud;
  endfunction

  function automatic longint clamp(longint v, int bits);
    longint hi, lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint map_coef(longint p1, longint p0, longint k);
    return clamp(rnd_div((p1 - p0) * 65536 + k * p1, 16), 40);
  endfunction

  function automatic coefs_t predict_coefs(quad_t q);
    coefs_t r;
    longint x0, y0, x1, y1, x2, y2, x3, y3;
    longint dx1, dx2, dx3, dy1, dy2, dy3, den, g, h;
    x0 = q.corner0_x; y0 = q.corner0_y; x1 = q.corner1_x; y1 = q.corner1_y;
    x2 = q.corner2_x; y2 = q.corner2_y; x3 = q.corner3_x; y3 = q.corner3_y;
    dx1 = x1 - x3; dx2 = x2 - x3; dx3 = x0 - x1 + x3 - x2;
    dy1 = y1 - y3; dy2 = y2 - y3; dy3 = y0 - y1 + y3 - y2;
    g = 0; h = 0;
    r = '0;
    r.coef_c = q.corner0_x;
    r.coef_f = q.corner0_y;
    if (dx3 == 0 && dy3 == 0) begin
      r.is_affine = 1'b1;
      r.coef_a = (x1 - x0) * 4096;
      r.coef_b = (x3 - x1) * 4096;
      r.coef_d = (y1 - y0) * 4096;
      r.coef_e = (y3 - y1) * 4096;
    end else begin
      den = dx1 * dy2 - dy1 * dx2;
      if (den == 0) begin
        r.degenerate = 1'b1;
      end else begin
        g = clamp(rnd_div((dx3 * dy2 - dy3 * dx2) * 65536, den), 32);
        h = clamp(rnd_div((dx1 * dy3 - dy1 * dx3) * 65536, den), 32);
      end
      r.coef_a = map_coef(x1, x0, g);
      r.coef_b = map_coef(x2, x0, h);
      r.coef_d = map_coef(y1, y0, g);
      r.coef_e = map_coef(y2, y0, h);
    end
    r.persp_g = g;
    r.persp_h = h;
    return r;
  endfunction

  // send one item, optionally with a typed expectation
  task automatic send_quad(quad_t q, bit use_typed, coefs_t typed);
    quad <= q;
    quad_valid <= 1'b1;
    expected_coefs.push_back(use_typed ? typed : predict_coefs(q));
    @(posedge clk);
    while (quad_stall) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic quad_t random_quad();
    quad_t q;
    int kind;
    q = {$urandom, $urandom, $urandom, $urandom};
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      // small coordinates keep the perspective terms in range
      q.corner0_x = $signed($urandom_range(0, 2047)) - 1024;
      q.corner0_y = $signed($urandom_range(0, 2047)) - 1024;
      q.corner1_x = $signed($urandom_range(0, 2047)) - 1024;
      q.corner1_y = $signed($urandom_range(0, 2047)) - 1024;
      q.corner2_x = $signed($urandom_range(0, 2047)) - 1024;
      q.corner2_y = $signed($urandom_range(0, 2047)) - 1024;
      q.corner3_x = $signed($urandom_range(0, 2047)) - 1024;
      q.corner3_y = $signed($urandom_range(0, 2047)) - 1024;
    end else if (kind < 6) begin
      // parallelogram
      q.corner3_x = q.corner1_x + q.corner2_x - q.corner0_x;
      q.corner3_y = q.corner1_y + q.corner2_y - q.corner0_y;
    end else if (kind == 6) begin
      // collinear spokes from corner3 give a zero divisor
      q.corner3_x = $signed($urandom_range(0, 255)) - 128;
      q.corner3_y = $signed($urandom_range(0, 255)) - 128;
      q.corner1_x = q.corner3_x + 16'sd3; q.corner1_y = q.corner3_y + 16'sd5;
      q.corner2_x = q.corner3_x - 16'sd6; q.corner2_y = q.corner3_y - 16'sd10;
      q.corner0_x = $signed($urandom_range(0, 4095)) - 2048;
    end
    return q;
  endfunction

  initial begin
    quad_t dir_q[N_DIRECTED];
    bit dir_typed[N_DIRECTED];
    coefs_t dir_exp[N_DIRECTED];
    coefs_t z;
    int burst;
    z = '0;
    for (int i = 0; i < N_DIRECTED; i++) begin
      dir_q[i] = '0; dir_typed[i] = 1'b0; dir_exp[i] = '0;
    end
    // all corners equal: parallelogram with zero coefficients
    dir_typed[0] = 1'b1; z.is_affine = 1'b1; dir_exp[0] = z;
    // unit square in Q12.4
    dir_q[1] = '{16'sd0, 16'sd0, 16'sd16, 16'sd0, 16'sd0, 16'sd16, 16'sd16, 16'sd16};
    dir_typed[1] = 1'b1; z = '0; z.is_affine = 1'b1;
    z.coef_a = 40'sd65536; z.coef_e = 40'sd65536; dir_exp[1] = z;
    // extremes of every field
    dir_q[2] = {8{16'sh7fff}};
    dir_q[3] = {8{16'sh8000}};
    dir_q[4] = '{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff,
                 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000};
    dir_q[5] = '{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000,
                 16'sh8000, 16'sh7fff, 16'sh0000, 16'sh0000};
    // zero divisor, not a parallelogram
    dir_q[6] = '{16'sd5, 16'sd0, 16'sd16, 16'sd16, 16'sd32, 16'sd32, 16'sd0, 16'sd0};
    dir_typed[6] = 1'b1; z = '0; z.degenerate = 1'b1;
    z.coef_c = 16'sd5; z.coef_a = 40'sd45056; z.coef_b = 40'sd110592;
    z.coef_d = 40'sd65536; z.coef_e = 40'sd131072; dir_exp[6] = z;
    // generic quads, perspective saturation
    dir_q[7] = '{16'sd0, 16'sd0, 16'sd20, 16'sd2, 16'sd3, 16'sd18, 16'sd25, 16'sd22};
    dir_q[8] = '{16'sd1000, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd1};
    dir_q[9] = '{16'sh7fff, 16'sh7fff, 16'sd1, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0};
    dir_q[10] = '{16'sh8000, 16'sd3, 16'sh7fff, 16'sh8000, 16'sd7, 16'sh7fff,
                  16'sh8000, 16'sh8000};
    dir_q[11] = '{16'sh5555, 16'shaaaa, 16'sh3333, 16'shcccc,
                  16'sh0f0f, 16'shf0f0, 16'sh00ff, 16'shff00};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    for (int i = 0; i < N_DIRECTED; i++) send_quad(dir_q[i], dir_typed[i], dir_exp[i]);
    quad_valid <= 1'b0;
    // hold off until every result is back
    while (expected_coefs.size() != 0) @(negedge clk);
    for (int n = 0; n < N_RANDOM;) begin
      burst = $urandom_range(1, 20);
      for (int k = 0; k < burst && n < N_RANDOM; k++, n++)
        send_quad(random_quad(), 1'b0, '0);
      if ($urandom_range(0, 2) != 0) begin
        quad_valid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
      if (n > N_RANDOM / 2 && n < N_RANDOM / 2 + 21) begin
        quad_valid <= 1'b0;
        while (expected_coefs.size() != 0) @(negedge clk);
      end
    end
    quad_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver stall pattern: runs of stall and no stall
  initial begin
    int run;
    forever begin
      run = $urandom_range(1, 30);
      coef_stall <= ($urandom_range(0, 3) == 0);
      repeat (run) @(negedge clk);
      if ($urandom_range(0, 4) == 0) begin
        coef_stall <= 1'b0;
        repeat ($urandom_range(20, 80)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    coefs_t want;
    if (!rst && coef_valid && !coef_stall) begin
      if (expected_coefs.size() == 0) begin
        $display("%0t: unexpected item, actual %h", $time, coefs);
        errors++;
      end else begin
        want = expected_coefs.pop_front();
        if (coefs.coef_a !== want.coef_a)
          $display("%0t: coef_a expected %0d actual %0d", $time, want.coef_a, coefs.coef_a);
        if (coefs.coef_b !== want.coef_b)
          $display("%0t: coef_b expected %0d actual %0d", $time, want.coef_b, coefs.coef_b);
        if (coefs.coef_c !== want.coef_c)
          $display("%0t: coef_c expected %0d actual %0d", $time, want.coef_c, coefs.coef_c);
        if (coefs.coef_d !== want.coef_d)
          $display("%0t: coef_d expected %0d actual %0d", $time, want.coef_d, coefs.coef_d);
        if (coefs.coef_e !== want.coef_e)
          $display("%0t: coef_e expected %0d actual %0d", $time, want.coef_e, coefs.coef_e);
        if (coefs.coef_f !== want.coef_f)
          $display("%0t: coef_f expected %0d actual %0d", $time, want.coef_f, coefs.coef_f);
        if (coefs.persp_g !== want.persp_g)
          $display("%0t: persp_g expected %0d actual %0d", $time, want.persp_g,
                   coefs.persp_g);
        if (coefs.persp_h !== want.persp_h)
          $display("%0t: persp_h expected %0d actual %0d", $time, want.persp_h,
                   coefs.persp_h);
        if (coefs.is_affine !== want.is_affine)
          $display("%0t: is_affine expected %0d actual %0d", $time, want.is_affine,
                   coefs.is_affine);
        if (coefs.degenerate !== want.degenerate)
          $display("%0t: degenerate expected %0d actual %0d", $time, want.degenerate,
                   coefs.degenerate);
        if (coefs !== want) errors++;
      end
    end
  end

  // watchdog on cycles with no accepted item
  always @(posedge clk) begin
    if ((quad_valid && !quad_stall) || (coef_valid && !coef_stall) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("square_to_quad_homography: mismatch");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    while (expected_coefs.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0 && expected_coefs.size() == 0)
      $display("square_to_quad_homography: match");
    else
      $display("square_to_quad_homography: mismatch");
    $finish;
  end

endmodule
